// ----- src/fbal_pkg.sv -----
// Package for the fit block allocator: payload types, codes and defaults.
`default_nettype none

package fbal_pkg;

  // Fixed field widths of the channels
  localparam int OP_W        = 2;
  localparam int SIZE_IN_W   = 16;
  localparam int STATUS_W    = 3;
  localparam int IDX_OUT_W   = 4;
  localparam int REM_OUT_W   = 16;
  localparam int FIT_MODE_W  = 2;

  // Defaults for the top level parameters
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_LOADED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ALLOC   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOFIT   = 3'd4;

  // Fit policy codes
  localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SIZE_IN_W-1:0] size;
  } fbal_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] block_index;
    logic [REM_OUT_W-1:0] remaining;
  } fbal_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } fbal_state_t;

endpackage

`default_nettype wire

// ----- src/fbal_ram.sv -----
// Generic single write port RAM with one registered read port.
`default_nettype none

module fbal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/fit_block_allocator_top.sv -----
// Top level of the fit block allocator: sequencer, shared compare unit, table.
//
// Usage: items enter on the in_ channel (op, size) and each yields exactly one
// result beat on the out_ channel (status, block_index, remaining). The cfg_
// channel writes the fit policy (first, best, worst) and is always ready; write
// it only while the block is idle.
// Clear, load, an unused op and an allocate on an empty table write the result
// register from the execute state once the output register is free. An
// allocate on a loaded table scans the blocks one per cycle through the block
// table's single read port, then writes its result from the finish state. One
// item is in work at a time; in_ready is high only while the sequencer is idle,
// which it re-enters as the result is written, so no item is accepted before
// the result of the last one has been written.
// A result waits in the output register while out_ready is low; the block
// still accepts the next item and holds its result step until the register
// frees, and no table update happens before that.
// Reset (rst_n low, synchronous) empties the table and selects first fit; the
// table memory itself is not cleared, so no clearing pass is needed.
`default_nettype none

module fit_block_allocator_top #(
  parameter int MAX_BLOCKS = fbal_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fbal_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fbal_pkg::fbal_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fbal_pkg::fbal_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbal_pkg::FIT_MODE_W-1:0]  cfg_data
);

  import fbal_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  fbal_state_t            state_r, state_nxt;
  logic [FIT_MODE_W-1:0]  fit_mode_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [SIZE_BITS-1:0]   req_r, req_nxt;
  logic [IDX_W-1:0]       iss_r, iss_nxt;
  logic                   iss_act_r, iss_act_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   found_r, found_nxt;
  logic [SIZE_BITS-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  fbal_out_t              out_data_r, out_data_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [SIZE_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [SIZE_BITS-1:0]   ram_rdata;

  logic [SIZE_BITS+SIZE_IN_W-1:0] size_ext;
  logic [SIZE_BITS-1:0]           size_in;
  logic [IDX_W+IDX_OUT_W-1:0]     load_idx_ext;
  logic [IDX_W+IDX_OUT_W-1:0]     grant_idx_ext;
  logic [SIZE_BITS+REM_OUT_W-1:0] req_rem_ext;
  logic [SIZE_BITS+REM_OUT_W-1:0] grant_rem_ext;
  logic [SIZE_BITS-1:0]           grant_rem;
  logic                           grant;
  logic                           out_free;
  logic                           iss_last;
  logic                           cand_fits, cand_lt, cand_gt, cand_take;

  // Fit the field widths to the table width
  assign size_ext      = {{SIZE_BITS{1'b0}}, in_data.size};
  assign size_in       = size_ext[SIZE_BITS-1:0];
  assign load_idx_ext  = {{IDX_OUT_W{1'b0}}, count_r[IDX_W-1:0]};
  assign grant_idx_ext = {{IDX_OUT_W{1'b0}}, best_idx_r};
  assign grant_rem     = best_r - req_r;
  assign req_rem_ext   = {{REM_OUT_W{1'b0}}, req_r};
  assign grant_rem_ext = {{REM_OUT_W{1'b0}}, grant_rem};

  assign out_free  = !out_valid_r || out_ready;
  assign iss_last  = (CNT_W'(iss_r) + CNT_W'(1)) == count_r;
  assign grant     = found_r && (best_r >= req_r);

  // Shared compare unit: judge one table entry against request and current pick
  assign cand_fits = ram_rdata >= req_r;
  assign cand_lt   = ram_rdata < best_r;
  assign cand_gt   = ram_rdata > best_r;

  always_comb begin
    if (fit_mode_r == FIT_BEST) begin
      cand_take = cand_fits && (!found_r || cand_lt);
    end else if (fit_mode_r == FIT_WORST) begin
      cand_take = !found_r || cand_gt;
    end else begin
      cand_take = cand_fits && !found_r;
    end
  end

  // Sequencer: next state, table access and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    iss_nxt       = iss_r;
    iss_act_nxt   = iss_act_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = rd_last_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = req_r;
    ram_re        = 1'b0;
    in_ready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_data.op;
          req_nxt   = size_in;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (op_r)
          OP_CLEAR: begin
            if (out_free) begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: STAT_CLEARED, block_index: '0, remaining: '0};
              state_nxt     = ST_IDLE;
            end
          end
          OP_LOAD: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
              if (count_r >= CNT_W'(MAX_BLOCKS)) begin
                out_data_nxt = '{status: STAT_FULL, block_index: '0, remaining: '0};
              end else begin
                ram_we       = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                out_data_nxt = '{status: STAT_LOADED,
                                 block_index: load_idx_ext[IDX_OUT_W-1:0],
                                 remaining: req_rem_ext[REM_OUT_W-1:0]};
              end
            end
          end
          OP_ALLOC: begin
            if (count_r == '0) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: STAT_NOFIT, block_index: '0, remaining: '0};
                state_nxt     = ST_IDLE;
              end
            end else begin
              iss_nxt     = '0;
              iss_act_nxt = 1'b1;
              found_nxt   = 1'b0;
              state_nxt   = ST_SCAN;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: STAT_NOFIT, block_index: '0, remaining: '0};
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end

      ST_SCAN: begin
        // Issue one table read per cycle
        if (iss_act_r) begin
          ram_re      = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = iss_r;
          rd_last_nxt = iss_last;
          if (iss_last) begin
            iss_act_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + IDX_W'(1);
          end
        end
        // Judge the entry read in the previous cycle
        if (rd_vld_r) begin
          if (cand_take) begin
            found_nxt    = 1'b1;
            best_nxt     = ram_rdata;
            best_idx_nxt = rd_idx_r;
          end
          if (rd_last_r) begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (grant) begin
            ram_we       = 1'b1;
            ram_waddr    = best_idx_r;
            ram_wdata    = grant_rem;
            out_data_nxt = '{status: STAT_ALLOC,
                             block_index: grant_idx_ext[IDX_OUT_W-1:0],
                             remaining: grant_rem_ext[REM_OUT_W-1:0]};
          end else begin
            out_data_nxt = '{status: STAT_NOFIT, block_index: '0, remaining: '0};
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fit_mode_r  <= FIT_FIRST;
      count_r     <= '0;
      iss_act_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_act_r   <= iss_act_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        fit_mode_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    iss_r      <= iss_nxt;
    rd_last_r  <= rd_last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table of remaining block sizes
  fbal_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (iss_r),
    .rd_data (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("table written during scan");

  a_pick_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && found_r) |-> (CNT_W'(best_idx_r) < count_r))
    else $error("picked block beyond loaded count");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == ST_SCAN && state_r == ST_SCAN))
    else $error("table read outside scan");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/fit_block_allocator_top_test.sv -----
// Self-checking testbench for fit_block_allocator_top: directed rows, then random table traffic.
`timescale 1ns / 100ps

module fit_block_allocator_top_test;
  import fbal_pkg::*;

  localparam int MAX_BLK = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_OPS = 1550;
  localparam int TAIL_CYCLES = 40;

  // Codes the package leaves unnamed
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [FIT_MODE_W-1:0] FIT_UNUSED = 2'd3;

  typedef enum logic {ROW_OP, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    fbal_in_t              item;
    logic [4:0]            reps;
    logic                  typed;
    fbal_out_t             res;
    logic [FIT_MODE_W-1:0] mode;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fbal_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fbal_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FIT_MODE_W-1:0] cfg_data = '0;

  // Shadow of the block table and policy
  logic [15:0] shadow_rem [MAX_BLK];
  logic [4:0] shadow_count = '0;
  logic [FIT_MODE_W-1:0] fit_mode_q = FIT_FIRST;

  fbal_out_t alloc_results_q[$];
  dir_row_t dir_rows[$];
  int err_count = 0;
  int ops_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int ready_mode = 0;
  int ready_left = 0;

  fit_block_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow table and return the result beat it causes
  function automatic fbal_out_t apply_op(input fbal_in_t item);
    fbal_out_t res;
    int pick;
    int i;
    res = '0;
    pick = -1;
    case (item.op)
      OP_CLEAR: begin
        shadow_count = '0;
        res.status = STAT_CLEARED;
      end
      OP_LOAD: begin
        if (shadow_count >= MAX_BLK) begin
          res.status = STAT_FULL;
        end else begin
          shadow_rem[shadow_count] = item.size;
          res.status = STAT_LOADED;
          res.block_index = shadow_count[3:0];
          res.remaining = item.size;
          shadow_count = shadow_count + 5'd1;
        end
      end
      OP_ALLOC: begin
        for (i = 0; i < shadow_count; i++) begin
          if (fit_mode_q == FIT_BEST) begin
            if (shadow_rem[i] >= item.size && (pick < 0 || shadow_rem[i] < shadow_rem[pick]))
              pick = i;
          end else if (fit_mode_q == FIT_WORST) begin
            if (pick < 0 || shadow_rem[i] > shadow_rem[pick])
              pick = i;
          end else if (pick < 0 && shadow_rem[i] >= item.size) begin
            pick = i;
          end
        end
        // Worst fit grants only if the largest block is big enough
        if (pick >= 0 && shadow_rem[pick] >= item.size) begin
          shadow_rem[pick] = shadow_rem[pick] - item.size;
          res.status = STAT_ALLOC;
          res.block_index = pick[3:0];
          res.remaining = shadow_rem[pick];
        end else begin
          res.status = STAT_NOFIT;
        end
      end
      default: begin
        res.status = STAT_NOFIT;
      end
    endcase
    return res;
  endfunction

  function automatic logic [15:0] block_size(input int grain);
    case (grain)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 8) * 64);
    endcase
  endfunction

  function automatic void add_op(input logic [OP_W-1:0] op, input logic [15:0] size,
                                 input int reps);
    dir_row_t row;
    row = '0;
    row.kind = ROW_OP;
    row.item.op = op;
    row.item.size = size;
    row.reps = reps[4:0];
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [OP_W-1:0] op, input logic [15:0] size,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [IDX_OUT_W-1:0] idx,
                                    input logic [REM_OUT_W-1:0] rem);
    dir_row_t row;
    row = '0;
    row.kind = ROW_OP;
    row.item.op = op;
    row.item.size = size;
    row.reps = 5'd1;
    row.typed = 1'b1;
    row.res = {status, idx, rem};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_mode(input logic [FIT_MODE_W-1:0] mode);
    dir_row_t row;
    row = '0;
    row.kind = ROW_MODE;
    row.mode = mode;
    dir_rows.push_back(row);
  endfunction

  // Send one beat, record its result, then maybe open a gap between bursts
  task automatic drive_op(input fbal_in_t item, input logic typed, input fbal_out_t typed_res);
    fbal_out_t predicted;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predicted = apply_op(item);
    alloc_results_q.push_back(typed ? typed_res : predicted);
    ops_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    end
  endtask

  // Hold the sender until every outstanding result has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_fit_mode(input logic [FIT_MODE_W-1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    fit_mode_q = mode;
    cfg_valid <= 1'b0;
  endtask

  // Check result beats in order; stall the receiver in stretches of varying density
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (alloc_results_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result beat: status %0d index %0d remaining %0d",
                   out_data.status, out_data.block_index, out_data.remaining);
      end else begin
        if (out_data.status !== alloc_results_q[0].status ||
            out_data.block_index !== alloc_results_q[0].block_index ||
            out_data.remaining !== alloc_results_q[0].remaining) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected status %0d index %0d remaining %0d, got %0d %0d %0d",
                     alloc_results_q[0].status, alloc_results_q[0].block_index,
                     alloc_results_q[0].remaining, out_data.status, out_data.block_index,
                     out_data.remaining);
        end
        void'(alloc_results_q.pop_front());
      end
    end
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(20, 200);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fit_block_allocator_top test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    fbal_in_t op_item;
    int r;
    int ph;
    int nseq;
    int nload;
    int nalloc;
    int grain;
    int pct;

    // Directed rows: empty table, extremes, each policy, full table
    add_typed(OP_ALLOC, 16'd0, STAT_NOFIT, 4'd0, 16'd0);
    add_typed(OP_UNUSED, 16'hFFFF, STAT_NOFIT, 4'd0, 16'd0);
    add_typed(OP_LOAD, 16'hFFFF, STAT_LOADED, 4'd0, 16'hFFFF);
    add_typed(OP_LOAD, 16'd0, STAT_LOADED, 4'd1, 16'd0);
    add_typed(OP_LOAD, 16'd300, STAT_LOADED, 4'd2, 16'd300);
    add_typed(OP_LOAD, 16'd120, STAT_LOADED, 4'd3, 16'd120);
    add_typed(OP_ALLOC, 16'd0, STAT_ALLOC, 4'd0, 16'hFFFF);
    add_op(OP_ALLOC, 16'd200, 1);
    add_typed(OP_ALLOC, 16'hFFFF, STAT_NOFIT, 4'd0, 16'd0);
    add_mode(FIT_BEST);
    add_op(OP_ALLOC, 16'd100, 1);
    add_op(OP_ALLOC, 16'd0, 1);
    add_mode(FIT_WORST);
    add_op(OP_ALLOC, 16'd1000, 1);
    add_typed(OP_ALLOC, 16'hFFFF, STAT_NOFIT, 4'd0, 16'd0);
    add_mode(FIT_UNUSED);
    add_op(OP_ALLOC, 16'd250, 1);
    add_typed(OP_CLEAR, 16'd0, STAT_CLEARED, 4'd0, 16'd0);
    add_typed(OP_ALLOC, 16'd1, STAT_NOFIT, 4'd0, 16'd0);
    add_op(OP_LOAD, 16'hA5A5, MAX_BLK);
    add_typed(OP_LOAD, 16'd1, STAT_FULL, 4'd0, 16'd0);
    add_op(OP_ALLOC, 16'hA5A5, 1);
    add_typed(OP_CLEAR, 16'hFFFF, STAT_CLEARED, 4'd0, 16'd0);
    add_mode(FIT_FIRST);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < dir_rows.size(); r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_MODE) begin
        settle();
        set_fit_mode(row.mode);
      end else begin
        repeat (row.reps) drive_op(row.item, row.typed, row.res);
      end
    end

    // Random phases: one policy each, mostly fill-then-allocate sequences
    ph = 0;
    while (ops_sent < TARGET_OPS) begin
      settle();
      case (ph % 4)
        0: set_fit_mode(FIT_FIRST);
        1: set_fit_mode(FIT_BEST);
        2: set_fit_mode(FIT_WORST);
        default: set_fit_mode(FIT_UNUSED);
      endcase
      ph++;
      nseq = $urandom_range(1, 3);
      repeat (nseq) begin
        if ($urandom_range(0, 99) < 85) begin
          grain = $urandom_range(0, 3);
          op_item.op = OP_CLEAR;
          op_item.size = 16'($urandom_range(0, 65535));
          drive_op(op_item, 1'b0, '0);
          nload = ($urandom_range(0, 9) == 0) ? MAX_BLK + $urandom_range(1, 3)
                                             : $urandom_range(1, MAX_BLK);
          repeat (nload) begin
            op_item.op = OP_LOAD;
            op_item.size = block_size(grain);
            drive_op(op_item, 1'b0, '0);
          end
          nalloc = $urandom_range(1, 20);
          repeat (nalloc) begin
            op_item.op = OP_ALLOC;
            pct = $urandom_range(0, 99);
            if (pct < 8)
              op_item.size = '0;
            else if (pct < 16)
              op_item.size = 16'($urandom_range(0, 65535));
            else if (pct < 30 && shadow_count > 0)
              op_item.size = shadow_rem[$urandom_range(0, shadow_count - 1)];
            else
              op_item.size = block_size(grain) / 16'($urandom_range(1, 4));
            drive_op(op_item, 1'b0, '0);
          end
        end else begin
          // Noise: any op, any size, including the unused op code
          repeat ($urandom_range(1, 6)) begin
            op_item.op = 2'($urandom_range(0, 3));
            op_item.size = 16'($urandom_range(0, 65535));
            drive_op(op_item, 1'b0, '0);
          end
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("fit_block_allocator_top test passed");
    end else begin
      $display("fit_block_allocator_top test failed");
    end
    $finish;
  end

endmodule
